@@ sv/gms_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package gms_pkg;

  localparam int GMS_MAX_COLS   = 128;
  localparam int GMS_MAX_ROWS   = 128;
  localparam int CFG_RESET_SIZE = 128;
  localparam int MIN_SIZE       = 3;
  localparam int NUM_W          = 36;

  localparam logic REG_NUM_COLS = 1'b0;
  localparam logic REG_NUM_ROWS = 1'b1;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum logic [1:0] {
    KIND_FWD,
    KIND_BWD,
    KIND_CEN
  } stencil_kind_t;

  typedef enum logic [2:0] {
    COEF_ZERO,
    COEF_P1,
    COEF_M1,
    COEF_P3,
    COEF_M3,
    COEF_P4,
    COEF_M4
  } coef_t;

  typedef logic signed [NUM_W-1:0] numer_t;
  typedef logic signed [31:0]      term_t;

  function automatic logic [7:0] clamp_size(input logic [7:0] v, input int max_size);
    logic [7:0] r;
    if (v < 8'(MIN_SIZE)) begin
      r = 8'(MIN_SIZE);
    end else if (int'(v) > max_size) begin
      r = 8'(max_size);
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic stencil_kind_t stencil_kind(input logic [7:0] pos,
                                                 input logic [7:0] count);
    stencil_kind_t k;
    if (pos == 8'd0) begin
      k = KIND_FWD;
    end else if (pos == count - 8'd1) begin
      k = KIND_BWD;
    end else begin
      k = KIND_CEN;
    end
    return k;
  endfunction

  function automatic logic [7:0] tap_pos(input stencil_kind_t kind, input logic [1:0] tap,
                                         input logic [7:0] pos);
    logic [7:0] r;
    case (kind)
      KIND_FWD: r = pos + 8'(tap);
      KIND_BWD: r = pos - 8'(tap);
      default: begin
        case (tap)
          2'd0:    r = pos + 8'd1;
          2'd1:    r = pos - 8'd1;
          default: r = pos;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic coef_t tap_coef(input stencil_kind_t kind, input logic [1:0] tap);
    coef_t c;
    case (kind)
      KIND_FWD: begin
        case (tap)
          2'd0:    c = COEF_M3;
          2'd1:    c = COEF_P4;
          default: c = COEF_M1;
        endcase
      end
      KIND_BWD: begin
        case (tap)
          2'd0:    c = COEF_P3;
          2'd1:    c = COEF_M4;
          default: c = COEF_P1;
        endcase
      end
      default: begin
        case (tap)
          2'd0:    c = COEF_P1;
          2'd1:    c = COEF_M1;
          default: c = COEF_ZERO;
        endcase
      end
    endcase
    return c;
  endfunction

  function automatic numer_t scale(input coef_t c, input term_t v);
    numer_t e;
    numer_t r;
    e = numer_t'(v);
    case (c)
      COEF_P1: r = e;
      COEF_M1: r = -e;
      COEF_P3: r = (e <<< 1) + e;
      COEF_M3: r = -((e <<< 1) + e);
      COEF_P4: r = e <<< 2;
      COEF_M4: r = -(e <<< 2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Halves with rounding to nearest, ties away from zero, then negates if asked
  // and saturates to 32 bits.
  function automatic term_t half_sat(input numer_t n, input logic neg);
    numer_t h;
    term_t  r;
    if (n >= 0) begin
      h = (n + numer_t'(1)) >>> 1;
    end else begin
      h = n >>> 1;
    end
    if (neg) begin
      h = -h;
    end
    if (h > numer_t'(32'sh7fffffff)) begin
      r = 32'sh7fffffff;
    end else if (h < numer_t'(32'sh80000000)) begin
      r = 32'sh80000000;
    end else begin
      r = h[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ sv/grid_metric_stencil_core.sv @@
// Grid metric stencil core.
// The input stream carries transactions of two kinds, chosen by s_tuser. A load
// writes one mesh point (x, y in Q16.16) into the coordinate memories and is
// taken without producing a result. A query names a point and
// yields one result transaction: four metric terms and the inverse Jacobian,
// or index_error with zero data if the point lies outside the configured grid.
// A query reads six stencil taps through the one read port of each coordinate
// memory, one tap per cycle, accumulating the finite-difference numerators by
// shift and add; the two Jacobian products then share a single 32 by 32
// multiplier. From the acceptance of a query until its result is in the result
// register, s_tready is low; an out-of-grid query skips the read, halving and
// multiply steps. Loads are accepted back to back.
// The result register holds a finished result while the receiver stalls, and
// further loads are still taken; a second query waits at its last step until
// the result register is free. Reset clears the sequencer, the result valid
// flag and sets both grid sizes to 128 (or the maximum, if smaller); the
// coordinate memories are not cleared and must be loaded before they are read.
`timescale 1ns / 1ps
`default_nettype none

module grid_metric_stencil_core
  import gms_pkg::*;
#(
  parameter int MAX_COLS = GMS_MAX_COLS,
  parameter int MAX_ROWS = GMS_MAX_ROWS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [7:0]   cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // Fields from bit 0: col_index[7], row_index[7], x_coord[32], y_coord[32], zero pad[2].
  input  wire logic [79:0]  s_tdata,
  // Fields from bit 0: req_type[1].
  input  wire logic         s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // Fields from bit 0: xi_x_term[32], xi_y_term[32], eta_x_term[32], eta_y_term[32],
  // inverse_jacobian[64].
  output logic [191:0]      m_tdata,
  // Fields from bit 0: index_error[1].
  output logic              m_tuser
);

  localparam int DEPTH = MAX_COLS * MAX_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [7:0] COLS_RESET = 8'((MAX_COLS < CFG_RESET_SIZE) ? MAX_COLS : CFG_RESET_SIZE);
  localparam logic [7:0] ROWS_RESET = 8'((MAX_ROWS < CFG_RESET_SIZE) ? MAX_ROWS : CFG_RESET_SIZE);
  localparam logic [2:0] LAST_TAP   = 3'd5;
  localparam logic [2:0] FIRST_XI   = 3'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_HALF,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } state_t;

  state_t state;

  logic [7:0] num_cols;
  logic [7:0] num_rows;

  logic [6:0]  in_col;
  logic [6:0]  in_row;
  term_t       in_x;
  term_t       in_y;
  logic        in_accept;
  logic        load_we;
  logic [AW-1:0] waddr;

  logic [7:0]  q_col;
  logic [7:0]  q_row;
  logic        q_err;
  logic [2:0]  cnt;

  stencil_kind_t kind_eta;
  stencil_kind_t kind_xi;
  logic [1:0]  tap;
  logic        tap_xi;
  logic [7:0]  rd_col;
  logic [7:0]  rd_row;
  logic [AW-1:0] raddr;
  coef_t       tap_c;

  logic        acc_en;
  logic        acc_xi;
  coef_t       acc_coef;
  logic [31:0] x_rd;
  logic [31:0] y_rd;
  numer_t      ax_eta;
  numer_t      ay_eta;
  numer_t      ax_xi;
  numer_t      ay_xi;

  term_t xi_x;
  term_t xi_y;
  term_t eta_x;
  term_t eta_y;

  term_t mul_a;
  term_t mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] p1;
  logic signed [63:0] p2;
  logic signed [64:0] jac_diff;
  logic signed [63:0] jac_sat;

  assign in_col    = s_tdata[6:0];
  assign in_row    = s_tdata[13:7];
  assign in_x      = s_tdata[45:14];
  assign in_y      = s_tdata[77:46];
  assign s_tready  = (state == ST_IDLE);
  assign in_accept = s_tvalid && s_tready;
  assign load_we   = in_accept && (s_tuser == REQ_LOAD)
                     && (32'(in_col) < MAX_COLS) && (32'(in_row) < MAX_ROWS);
  assign waddr     = AW'(32'(in_row) * MAX_COLS + 32'(in_col));

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols <= COLS_RESET;
      num_rows <= ROWS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_COLS: num_cols <= clamp_size(cfg_wdata, MAX_COLS);
        REG_NUM_ROWS: num_rows <= clamp_size(cfg_wdata, MAX_ROWS);
        default: ;
      endcase
    end
  end

  // Taps 0 to 2 walk along the column (eta direction), taps 3 to 5 along the row.
  always_comb begin
    kind_eta = stencil_kind(q_row, num_rows);
    kind_xi  = stencil_kind(q_col, num_cols);
    tap_xi   = (cnt >= FIRST_XI);
    tap      = tap_xi ? 2'(cnt - FIRST_XI) : cnt[1:0];
    if (tap_xi) begin
      rd_row = q_row;
      rd_col = tap_pos(kind_xi, tap, q_col);
      tap_c  = tap_coef(kind_xi, tap);
    end else begin
      rd_row = tap_pos(kind_eta, tap, q_row);
      rd_col = q_col;
      tap_c  = tap_coef(kind_eta, tap);
    end
    raddr = AW'(32'(rd_row) * MAX_COLS + 32'(rd_col));
  end

  gms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_x_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (in_x),
    .raddr (raddr),
    .rdata (x_rd)
  );

  gms_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_y_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (waddr),
    .wdata (in_y),
    .raddr (raddr),
    .rdata (y_rd)
  );

  always_comb begin
    if (state == ST_MUL1) begin
      mul_a = xi_x;
      mul_b = eta_y;
    end else begin
      mul_a = eta_x;
      mul_b = xi_y;
    end
    prod     = 64'(mul_a) * 64'(mul_b);
    jac_diff = 65'(p1) - 65'(p2);
    if (jac_diff[64] != jac_diff[63]) begin
      jac_sat = jac_diff[64] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
    end else begin
      jac_sat = jac_diff[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      acc_en   <= 1'b0;
      cnt      <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      acc_en   <= (state == ST_READ) && (cnt <= LAST_TAP);
      acc_xi   <= tap_xi;
      acc_coef <= tap_c;
      if (acc_en) begin
        if (acc_xi) begin
          ax_xi <= ax_xi + scale(acc_coef, x_rd);
          ay_xi <= ay_xi + scale(acc_coef, y_rd);
        end else begin
          ax_eta <= ax_eta + scale(acc_coef, x_rd);
          ay_eta <= ay_eta + scale(acc_coef, y_rd);
        end
      end
      case (state)
        ST_IDLE: begin
          if (in_accept && (s_tuser == REQ_QUERY)) begin
            q_col  <= 8'(in_col);
            q_row  <= 8'(in_row);
            q_err  <= (8'(in_col) >= num_cols) || (8'(in_row) >= num_rows);
            cnt    <= '0;
            ax_eta <= '0;
            ay_eta <= '0;
            ax_xi  <= '0;
            ay_xi  <= '0;
            if ((8'(in_col) >= num_cols) || (8'(in_row) >= num_rows)) begin
              state <= ST_FIN;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          cnt <= cnt + 3'd1;
          if (cnt == LAST_TAP + 3'd1) begin
            state <= ST_HALF;
          end
        end
        ST_HALF: begin
          xi_x  <= half_sat(ay_eta, 1'b0);
          xi_y  <= half_sat(ax_eta, 1'b1);
          eta_x <= half_sat(ay_xi, 1'b1);
          eta_y <= half_sat(ax_xi, 1'b0);
          state <= ST_MUL1;
        end
        ST_MUL1: begin
          p1    <= prod;
          state <= ST_MUL2;
        end
        ST_MUL2: begin
          p2    <= prod;
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= q_err;
            if (q_err) begin
              m_tdata <= '0;
            end else begin
              m_tdata <= {jac_sat, eta_y, eta_x, xi_y, xi_x};
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == REQ_QUERY)) |=> !s_tready)
    else $error("query accepted without blocking the input");

  a_load_no_block: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == REQ_LOAD)) |=> s_tready)
    else $error("load transaction stalled the input");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("index error result carries non-zero data");

  a_tap_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (cnt <= LAST_TAP + 3'd1))
    else $error("tap counter overran");

  a_acc_only_read: assert property (@(posedge clk) disable iff (rst)
    acc_en |-> ($past(state) == ST_READ))
    else $error("accumulation outside the read phase");

endmodule

`default_nettype wire

@@ sv/gms_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module gms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
